### rtl/motor_command_packer_core_assert.svh
// ----------------------------------------------------------------------------
// motor command packer assertion macros
// Concurrent checks used inside the packer, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_PACKER_CORE_ASSERT_SVH
`define MOTOR_COMMAND_PACKER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent checked in the same cycle as the antecedent
`define MCP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcp: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define MCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcp: next-cycle check failed");

`else

`define MCP_ASSERT_SAME(label, clk, rst, ante, cons)
`define MCP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg
// Types and constants shared by the motor command packer modules.
// ----------------------------------------------------------------------------
package mcp_pkg;

   localparam int DATA_W        = 32;
   localparam int LIMIT_W       = 31;
   localparam int ID_W          = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 31;
   localparam int POS_CODE_W    = 16;
   localparam int FIELD_CODE_W  = 12;
   localparam int NIBBLE_W      = 4;
   localparam int LANES         = 5;

   localparam int POSITION_BITS_DEF = 16;
   localparam int FIELD_BITS_DEF    = 12;

   localparam logic [ID_W-1:0]    MOTOR_ID_RST        = 8'd1;
   localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST  = 31'd819200;
   localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RST  = 31'd4259840;
   localparam logic [LIMIT_W-1:0] STIFFNESS_LIMIT_RST = 31'd32768000;
   localparam logic [LIMIT_W-1:0] DAMPING_LIMIT_RST   = 31'd327680;
   localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST   = 31'd1179648;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MOTOR_ID        = 3'd0,
      CSR_POSITION_LIMIT  = 3'd1,
      CSR_VELOCITY_LIMIT  = 3'd2,
      CSR_STIFFNESS_LIMIT = 3'd3,
      CSR_DAMPING_LIMIT   = 3'd4,
      CSR_CURRENT_LIMIT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] target_position;
      logic signed [DATA_W-1:0] target_velocity;
      logic signed [DATA_W-1:0] stiffness_gain;
      logic signed [DATA_W-1:0] damping_gain;
      logic signed [DATA_W-1:0] feedforward_current;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte0;
      logic [7:0] frame_byte1;
      logic [7:0] frame_byte2;
      logic [7:0] frame_byte3;
      logic [7:0] frame_byte4;
      logic [7:0] frame_byte5;
      logic [7:0] frame_byte6;
      logic [7:0] frame_byte7;
      logic [7:0] frame_byte8;
   } rsp_type;

endpackage

### rtl/mcp_lane_front.sv
// ----------------------------------------------------------------------------
// mcp_lane_front
// Clamps one command value and forms the scaled dividend offset * (2^bits - 1).
// ----------------------------------------------------------------------------
module mcp_lane_front #(
   parameter int CODE_BITS = mcp_pkg::FIELD_BITS_DEF,
   parameter int STEPS     = mcp_pkg::POSITION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic                                  sym,
   input  logic [mcp_pkg::LIMIT_W-1:0]           limit,
   input  logic [mcp_pkg::DATA_W-1:0]            span,
   input  logic signed [mcp_pkg::DATA_W-1:0]     value,
   output logic [mcp_pkg::DATA_W+STEPS-1:0]      num
);

   localparam int NUM_W = mcp_pkg::DATA_W + STEPS;
   localparam int EXT_W = mcp_pkg::DATA_W + 2;

   logic signed [EXT_W-1:0]           base;
   logic signed [mcp_pkg::DATA_W:0]   value_ext;
   logic signed [mcp_pkg::DATA_W:0]   limit_ext;
   logic                              below;
   logic                              above;
   logic [mcp_pkg::DATA_W-1:0]        off_in;
   logic [mcp_pkg::DATA_W-1:0]        off_ff;
   logic [NUM_W-1:0]                  num_in;
   logic [NUM_W-1:0]                  num_ff;

   always_comb begin
      value_ext = (mcp_pkg::DATA_W+1)'(value);
      limit_ext = $signed({2'b00, limit});
      // symmetric range is shifted up by the limit so the low bound sits at zero
      if (sym) begin
         base = EXT_W'(value) + $signed({3'b000, limit});
      end else begin
         base = EXT_W'(value);
      end
      below = base[EXT_W-1];
      above = value_ext > limit_ext;
      if (below) begin
         off_in = '0;
      end else if (above) begin
         off_in = span;
      end else begin
         off_in = base[mcp_pkg::DATA_W-1:0];
      end
      num_in = (NUM_W'(off_ff) << CODE_BITS) - NUM_W'(off_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         off_ff <= off_in;
         num_ff <= num_in;
      end
   end

   assign num = num_ff;

endmodule

### rtl/mcp_div_step.sv
// ----------------------------------------------------------------------------
// mcp_div_step
// One registered restoring division step: remainder in the upper part,
// dividend bits shifting out and quotient bits shifting in at the bottom.
// ----------------------------------------------------------------------------
module mcp_div_step #(
   parameter int STEPS = mcp_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [mcp_pkg::DATA_W-1:0]          span,
   input  logic [mcp_pkg::DATA_W+STEPS-1:0]    acc_in,
   output logic [mcp_pkg::DATA_W+STEPS-1:0]    acc_out
);

   localparam int NUM_W = mcp_pkg::DATA_W + STEPS;

   logic [mcp_pkg::DATA_W:0]     trial;
   logic [mcp_pkg::DATA_W:0]     diff;
   logic                         fits;
   logic [mcp_pkg::DATA_W-1:0]   rem_next;
   logic [NUM_W-1:0]             acc_in_next;
   logic [NUM_W-1:0]             acc_ff;

   always_comb begin
      trial = acc_in[NUM_W-1:STEPS-1];
      diff  = trial - {1'b0, span};
      fits  = trial >= {1'b0, span};
      // remainder stays below span, so one bit is dropped safely
      rem_next    = fits ? diff[mcp_pkg::DATA_W-1:0] : trial[mcp_pkg::DATA_W-1:0];
      acc_in_next = {rem_next, acc_in[STEPS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in_next;
      end
   end

   assign acc_out = acc_ff;

endmodule

### rtl/mcp_div_pipe.sv
// ----------------------------------------------------------------------------
// mcp_div_pipe
// Pipelined divider, one quotient bit per stage, quotient fits in STEPS bits.
// ----------------------------------------------------------------------------
module mcp_div_pipe #(
   parameter int STEPS = mcp_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [mcp_pkg::DATA_W-1:0]          span,
   input  logic [mcp_pkg::DATA_W+STEPS-1:0]    num,
   output logic [STEPS-1:0]                    quot
);

   localparam int NUM_W = mcp_pkg::DATA_W + STEPS;

   logic [NUM_W-1:0] chain [STEPS+1];

   assign chain[0] = num;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      mcp_div_step #(
         .STEPS (STEPS)
      ) u_step (
         .clock   (clock),
         .advance (advance),
         .span    (span),
         .acc_in  (chain[s]),
         .acc_out (chain[s+1])
      );
   end

   assign quot = chain[STEPS][STEPS-1:0];

endmodule

### rtl/motor_command_packer_core.sv
// ----------------------------------------------------------------------------
// motor_command_packer_core
// Clamps and scales one impedance joint command and packs it into a 9-byte
// actuator frame.
// ----------------------------------------------------------------------------
// Usage: an item on req_data (five signed Q16.16 values) is taken when
// req_valid and req_ready are both high. One frame comes out on rsp_data per
// item, in order, held until rsp_valid and rsp_ready are both high.
// Limits and the motor id are written through csr_wr_en / csr_index /
// csr_wdata while no item is in flight; unknown indexes are dropped.
// Pipeline: the item passes one clamp stage, one dividend stage, one divider
// stage per quotient bit and the frame register before the frame is valid.
// Throughput: one item per cycle while the output is not stalled; each divider
// stage is a single 33-bit compare and subtract.
// Stall: when rsp_valid is high and rsp_ready low, the whole pipeline freezes
// and req_ready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, clears the pipeline valid bits and the frame valid and
// loads the default limits and motor id.
// ----------------------------------------------------------------------------
`include "motor_command_packer_core_assert.svh"

module motor_command_packer_core #(
   parameter int POSITION_BITS = mcp_pkg::POSITION_BITS_DEF,
   parameter int FIELD_BITS    = mcp_pkg::FIELD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mcp_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mcp_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [mcp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mcp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int STEPS = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
   localparam int NUM_W = mcp_pkg::DATA_W + STEPS;
   localparam int DEPTH = STEPS + 2;

   logic [mcp_pkg::ID_W-1:0]    motor_id_ff;
   logic [mcp_pkg::LIMIT_W-1:0] position_limit_ff;
   logic [mcp_pkg::LIMIT_W-1:0] velocity_limit_ff;
   logic [mcp_pkg::LIMIT_W-1:0] stiffness_limit_ff;
   logic [mcp_pkg::LIMIT_W-1:0] damping_limit_ff;
   logic [mcp_pkg::LIMIT_W-1:0] current_limit_ff;

   logic                         advance;
   logic [DEPTH-1:0]             valid_ff;
   logic [DEPTH-1:0]             valid_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   mcp_pkg::rsp_type             rsp_ff;
   mcp_pkg::rsp_type             rsp_in;

   logic signed [mcp_pkg::DATA_W-1:0] lane_value [mcp_pkg::LANES];
   logic [mcp_pkg::LIMIT_W-1:0]       lane_limit [mcp_pkg::LANES];
   logic                              lane_sym   [mcp_pkg::LANES];
   logic [mcp_pkg::DATA_W-1:0]        lane_span  [mcp_pkg::LANES];
   logic [NUM_W-1:0]                  lane_num   [mcp_pkg::LANES];
   logic [STEPS-1:0]                  lane_quot  [mcp_pkg::LANES];

   logic                              pos_limit_zero;
   logic [mcp_pkg::POS_CODE_W-1:0]    rsp_pos_code;
   logic [mcp_pkg::POS_CODE_W-1:0]    pos_code;
   logic [mcp_pkg::FIELD_CODE_W-1:0]  vel_code;
   logic [mcp_pkg::FIELD_CODE_W-1:0]  kp_code;
   logic [mcp_pkg::FIELD_CODE_W-1:0]  kd_code;
   logic [mcp_pkg::FIELD_CODE_W-1:0]  ff_code;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff        <= mcp_pkg::MOTOR_ID_RST;
         position_limit_ff  <= mcp_pkg::POSITION_LIMIT_RST;
         velocity_limit_ff  <= mcp_pkg::VELOCITY_LIMIT_RST;
         stiffness_limit_ff <= mcp_pkg::STIFFNESS_LIMIT_RST;
         damping_limit_ff   <= mcp_pkg::DAMPING_LIMIT_RST;
         current_limit_ff   <= mcp_pkg::CURRENT_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (mcp_pkg::csr_index_type'(csr_index))
            mcp_pkg::CSR_MOTOR_ID: begin
               motor_id_ff <= csr_wdata[mcp_pkg::ID_W-1:0];
            end
            mcp_pkg::CSR_POSITION_LIMIT: begin
               position_limit_ff <= csr_wdata[mcp_pkg::LIMIT_W-1:0];
            end
            mcp_pkg::CSR_VELOCITY_LIMIT: begin
               velocity_limit_ff <= csr_wdata[mcp_pkg::LIMIT_W-1:0];
            end
            mcp_pkg::CSR_STIFFNESS_LIMIT: begin
               stiffness_limit_ff <= csr_wdata[mcp_pkg::LIMIT_W-1:0];
            end
            mcp_pkg::CSR_DAMPING_LIMIT: begin
               damping_limit_ff <= csr_wdata[mcp_pkg::LIMIT_W-1:0];
            end
            mcp_pkg::CSR_CURRENT_LIMIT: begin
               current_limit_ff <= csr_wdata[mcp_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // whole pipeline moves together; frozen only while a frame waits
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      lane_value[0] = req_data.target_position;
      lane_value[1] = req_data.target_velocity;
      lane_value[2] = req_data.stiffness_gain;
      lane_value[3] = req_data.damping_gain;
      lane_value[4] = req_data.feedforward_current;
      lane_limit[0] = position_limit_ff;
      lane_limit[1] = velocity_limit_ff;
      lane_limit[2] = stiffness_limit_ff;
      lane_limit[3] = damping_limit_ff;
      lane_limit[4] = current_limit_ff;
      lane_sym[0]   = 1'b1;
      lane_sym[1]   = 1'b1;
      lane_sym[2]   = 1'b0;
      lane_sym[3]   = 1'b0;
      lane_sym[4]   = 1'b1;
   end

   // limits must be static while items are in flight (the block does not enforce it), so lanes read them live
   for (genvar g = 0; g < mcp_pkg::LANES; g++) begin : g_lane
      localparam int LANE_BITS = (g == 0) ? POSITION_BITS : FIELD_BITS;

      assign lane_span[g] = lane_sym[g] ? {lane_limit[g], 1'b0} : {1'b0, lane_limit[g]};

      mcp_lane_front #(
         .CODE_BITS (LANE_BITS),
         .STEPS     (STEPS)
      ) u_front (
         .clock   (clock),
         .advance (advance),
         .sym     (lane_sym[g]),
         .limit   (lane_limit[g]),
         .span    (lane_span[g]),
         .value   (lane_value[g]),
         .num     (lane_num[g])
      );

      mcp_div_pipe #(
         .STEPS (STEPS)
      ) u_div (
         .clock   (clock),
         .advance (advance),
         .span    (lane_span[g]),
         .num     (lane_num[g]),
         .quot    (lane_quot[g])
      );
   end

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
      if (advance) begin
         rsp_valid_in = valid_ff[DEPTH-1];
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // a zero limit means a zero span, and the code is forced to zero
      pos_limit_zero = (position_limit_ff == '0);
      pos_code = pos_limit_zero ? '0 :
                 mcp_pkg::POS_CODE_W'(lane_quot[0][POSITION_BITS-1:0]);
      vel_code = (velocity_limit_ff == '0) ? '0 :
                 mcp_pkg::FIELD_CODE_W'(lane_quot[1][FIELD_BITS-1:0]);
      kp_code  = (stiffness_limit_ff == '0) ? '0 :
                 mcp_pkg::FIELD_CODE_W'(lane_quot[2][FIELD_BITS-1:0]);
      kd_code  = (damping_limit_ff == '0) ? '0 :
                 mcp_pkg::FIELD_CODE_W'(lane_quot[3][FIELD_BITS-1:0]);
      ff_code  = (current_limit_ff == '0) ? '0 :
                 mcp_pkg::FIELD_CODE_W'(lane_quot[4][FIELD_BITS-1:0]);

      rsp_in.frame_byte0 = motor_id_ff;
      rsp_in.frame_byte1 = pos_code[15:8];
      rsp_in.frame_byte2 = pos_code[7:0];
      rsp_in.frame_byte3 = vel_code[11:4];
      rsp_in.frame_byte4 = {vel_code[mcp_pkg::NIBBLE_W-1:0], kp_code[11:8]};
      rsp_in.frame_byte5 = kp_code[7:0];
      rsp_in.frame_byte6 = kd_code[11:4];
      rsp_in.frame_byte7 = {kd_code[mcp_pkg::NIBBLE_W-1:0], ff_code[11:8]};
      rsp_in.frame_byte8 = ff_code[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign rsp_pos_code = {rsp_ff.frame_byte1, rsp_ff.frame_byte2};

   `MCP_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && req_ready, valid_ff[0])
   `MCP_ASSERT_NEXT(a_stall_freezes_pipe, clock, reset, rsp_valid && !rsp_ready, $stable(valid_ff))
   `MCP_ASSERT_NEXT(a_last_stage_to_frame, clock, reset, valid_ff[DEPTH-1] && advance, rsp_valid_ff)
   `MCP_ASSERT_SAME(a_zero_pos_code, clock, reset, rsp_valid && pos_limit_zero, rsp_pos_code == '0)

endmodule
